/* hdl/tgse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tgse_pkg;

   localparam int COMPONENTS   = 3;
   localparam int DIV_STEPS    = 31;
   localparam int SERIES_TERMS = 12;
   localparam int SQUARINGS    = 5;
   localparam int EXP_LAT      = 3 * SERIES_TERMS + SQUARINGS;
   localparam int SIDE_LAT     = DIV_STEPS + EXP_LAT;
   localparam int COMP_LAT     = 1 + SIDE_LAT + 1;

   localparam logic [31:0] ONE_Q31  = 32'h8000_0000;
   localparam logic [63:0] HALF_Q31 = 64'h0000_0000_4000_0000;

   localparam logic [47:0] GAUSS_RESET [3] = '{
      48'h0100_0000_0000,
      48'h0100_0000_0280,
      48'h0100_000F_4080
   };

   // floor(2^32 / k) for the series divisors.
   localparam logic [32:0] RECIP [13] = '{
      33'h0_0000_0000,
      33'h1_0000_0000,
      33'h0_8000_0000,
      33'h0_5555_5555,
      33'h0_4000_0000,
      33'h0_3333_3333,
      33'h0_2AAA_AAAA,
      33'h0_2492_4924,
      33'h0_2000_0000,
      33'h0_1C71_C71C,
      33'h0_1999_9999,
      33'h0_1745_D174,
      33'h0_1555_5555
   };

   typedef enum logic [1:0] {
      CSR_OFFSET      = 2'd0,
      CSR_GAUSS_ONE   = 2'd1,
      CSR_GAUSS_TWO   = 2'd2,
      CSR_GAUSS_THREE = 2'd3
   } csr_index_type;

endpackage

`default_nettype wire

/* hdl/tgse_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module tgse_div
   import tgse_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [31:0] d2,
   input  wire logic [31:0] w2,
   output logic      [30:0] quot
);

   logic [31:0] rem_ff [DIV_STEPS-1];
   logic [31:0] den_ff [DIV_STEPS-1];
   logic [30:0] q_ff   [DIV_STEPS];
   logic [5:0]  lo_ff  [DIV_STEPS-1];

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      logic [31:0] rin;
      logic [31:0] den_src;
      logic [30:0] q_src;
      logic [5:0]  lo_src;
      logic [32:0] sh;
      logic [32:0] diff;
      logic        ge;
      logic [30:0] q_in;

      if (i == 0) begin : g_first
         assign rin     = {6'd0, d2[31:6]};
         assign den_src = w2;
         assign q_src   = '0;
         assign lo_src  = d2[5:0];
      end else begin : g_next
         assign rin     = rem_ff[i-1];
         assign den_src = den_ff[i-1];
         assign q_src   = q_ff[i-1];
         assign lo_src  = lo_ff[i-1];
      end

      assign sh     = {rin, lo_src[5]};
      assign diff   = sh - {1'b0, den_src};
      assign ge     = !diff[32];
      assign q_in   = {q_src[29:0], ge};

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[i] <= q_in;
         end
      end

      if (i < DIV_STEPS - 1) begin : g_lo
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= ge ? diff[31:0] : sh[31:0];
               den_ff[i] <= den_src;
               lo_ff[i]  <= {lo_src[4:0], 1'b0};
            end
         end
      end
   end

   assign quot = q_ff[DIV_STEPS-1];

endmodule

`default_nettype wire

/* hdl/tgse_exp.sv */
`timescale 1ns / 1ps
`default_nettype none

module tgse_exp
   import tgse_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [30:0] y,
   output logic      [31:0] e
);

   localparam int YD = 3 * (SERIES_TERMS - 1);

   logic [30:0] yd_ff  [YD];
   logic [62:0] p_ff   [SERIES_TERMS];
   logic [30:0] n_ff   [SERIES_TERMS];
   logic [30:0] q0_ff  [SERIES_TERMS];
   logic [31:0] acc_ff [SERIES_TERMS];
   logic [31:0] sq_ff  [SQUARINGS];

   for (genvar m = 0; m < YD; m++) begin : g_ydly
      if (m == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (en) begin
               yd_ff[m] <= y;
            end
         end
      end else begin : g_tail
         always_ff @(posedge clock) begin
            if (en) begin
               yd_ff[m] <= yd_ff[m-1];
            end
         end
      end
   end

   for (genvar j = 0; j < SERIES_TERMS; j++) begin : g_term
      localparam int K  = SERIES_TERMS - j;
      localparam int KH = K / 2;
      logic [30:0] y_src;
      logic [31:0] acc_src;
      logic [62:0] p_in;
      logic [63:0] pr;
      logic [30:0] n_in;
      logic [63:0] qm;
      logic [30:0] q0_in;
      logic [34:0] qk;
      logic [34:0] r;
      logic [30:0] q;
      logic [31:0] acc_in;

      if (j == 0) begin : g_first
         assign y_src   = y;
         assign acc_src = ONE_Q31;
      end else begin : g_next
         assign y_src   = yd_ff[3*j-1];
         assign acc_src = acc_ff[j-1];
      end

      assign p_in   = 63'(y_src) * 63'(acc_src);
      assign pr     = {1'b0, p_ff[j]} + HALF_Q31;
      assign n_in   = pr[61:31] + 31'(KH);
      assign qm     = 64'(n_in) * 64'(RECIP[K]);
      assign q0_in  = qm[62:32];
      assign qk     = 35'(q0_ff[j]) * 35'(K);
      assign r      = 35'(n_ff[j]) - qk;
      assign q      = (r >= 35'(K)) ? q0_ff[j] + 31'd1 : q0_ff[j];
      assign acc_in = ONE_Q31 - {1'b0, q};

      always_ff @(posedge clock) begin
         if (en) begin
            p_ff[j]   <= p_in;
            n_ff[j]   <= n_in;
            q0_ff[j]  <= q0_in;
            acc_ff[j] <= acc_in;
         end
      end
   end

   for (genvar i = 0; i < SQUARINGS; i++) begin : g_sq
      logic [31:0] src;
      logic [63:0] prod;
      logic [63:0] rnd;

      if (i == 0) begin : g_first
         assign src = acc_ff[SERIES_TERMS-1];
      end else begin : g_next
         assign src = sq_ff[i-1];
      end

      assign prod = 64'(src) * 64'(src);
      assign rnd  = prod + HALF_Q31;

      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[i] <= rnd[62:31];
         end
      end
   end

   assign e = sq_ff[SQUARINGS-1];

endmodule

`default_nettype wire

/* hdl/tgse_comp.sv */
`timescale 1ns / 1ps
`default_nettype none

module tgse_comp
   import tgse_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [15:0] t,
   input  wire logic        [47:0] gauss,
   output logic      signed [48:0] contrib
);

   logic signed [15:0] amp;
   logic signed [15:0] pos;
   logic        [15:0] wid;
   logic signed [16:0] d;
   logic        [15:0] ad;
   logic        [31:0] d2_in;
   logic        [31:0] w2_in;

   logic        [31:0] d2_ff;
   logic        [31:0] w2_ff;
   logic signed [15:0] amp_ff;
   logic               wz_ff;
   logic               kill;

   logic signed [15:0] amp_sd_ff  [SIDE_LAT];
   logic               kill_sd_ff [SIDE_LAT];

   logic        [30:0] y;
   logic        [31:0] e;
   logic signed [32:0] e_s;
   logic signed [48:0] contrib_in;
   logic signed [48:0] contrib_ff;

   assign amp   = gauss[15:0];
   assign pos   = gauss[31:16];
   assign wid   = gauss[47:32];
   assign d     = {t[15], t} - {pos[15], pos};
   assign ad    = d[16] ? 16'(-d) : d[15:0];
   assign d2_in = 32'(ad) * 32'(ad);
   assign w2_in = 32'(wid) * 32'(wid);

   always_ff @(posedge clock) begin
      if (en) begin
         d2_ff  <= d2_in;
         w2_ff  <= w2_in;
         amp_ff <= amp;
         wz_ff  <= (wid == 16'd0);
      end
   end

   assign kill = wz_ff || ({5'd0, d2_ff} > {w2_ff, 5'd0});

   tgse_div u_div (
      .clock (clock),
      .en    (en),
      .d2    (d2_ff),
      .w2    (w2_ff),
      .quot  (y)
   );

   tgse_exp u_exp (
      .clock (clock),
      .en    (en),
      .y     (y),
      .e     (e)
   );

   for (genvar m = 0; m < SIDE_LAT; m++) begin : g_side
      if (m == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (en) begin
               amp_sd_ff[m]  <= amp_ff;
               kill_sd_ff[m] <= kill;
            end
         end
      end else begin : g_tail
         always_ff @(posedge clock) begin
            if (en) begin
               amp_sd_ff[m]  <= amp_sd_ff[m-1];
               kill_sd_ff[m] <= kill_sd_ff[m-1];
            end
         end
      end
   end

   assign e_s        = $signed({1'b0, e});
   assign contrib_in = kill_sd_ff[SIDE_LAT-1] ? 49'sd0 : amp_sd_ff[SIDE_LAT-1] * e_s;

   always_ff @(posedge clock) begin
      if (en) begin
         contrib_ff <= contrib_in;
      end
   end

   assign contrib = contrib_ff;

endmodule

`default_nettype wire

/* hdl/three_gaussian_sum_eval.sv */
// Throughput: one sample per cycle while the output is not stalled; the 31-step
// divider and 12-term series run as fully pipelined stages, so every stage can
// hold a different sample. A stall on rsp_ready freezes the whole pipeline and
// deasserts req_ready.
// Synchronous reset empties the pipeline and loads the default register values.
`timescale 1ns / 1ps
`default_nettype none

module three_gaussian_sum_eval
   import tgse_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_sample_pos,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [18:0] rsp_model_value,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [47:0] csr_wdata
);

   localparam int PIPE_LAT = 1 + COMP_LAT + 2;

   logic [15:0]           offset_ff;
   logic [47:0]           gauss_ff [3];
   logic [PIPE_LAT-1:0]   vld_ff;
   logic [PIPE_LAT-1:0]   vld_in;
   logic                  en;
   logic signed [15:0]    t_ff;
   logic signed [48:0]    contrib [COMPONENTS];
   logic signed [50:0]    sum_in;
   logic signed [50:0]    sum_ff;
   logic signed [50:0]    rnd;
   logic [18:0]           out_ff;

   assign en        = !vld_ff[PIPE_LAT-1] || rsp_ready;
   assign req_ready = en;
   assign vld_in    = {vld_ff[PIPE_LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= '0;
         gauss_ff[0] <= GAUSS_RESET[0];
         gauss_ff[1] <= GAUSS_RESET[1];
         gauss_ff[2] <= GAUSS_RESET[2];
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_OFFSET:      offset_ff   <= csr_wdata[15:0];
            CSR_GAUSS_ONE:   gauss_ff[0] <= csr_wdata;
            CSR_GAUSS_TWO:   gauss_ff[1] <= csr_wdata;
            CSR_GAUSS_THREE: gauss_ff[2] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff <= req_sample_pos;
      end
   end

   for (genvar i = 0; i < COMPONENTS; i++) begin : g_comp
      tgse_comp u_comp (
         .clock   (clock),
         .en      (en),
         .t       (t_ff),
         .gauss   (gauss_ff[i]),
         .contrib (contrib[i])
      );
   end

   always_comb begin
      sum_in = $signed({{4{offset_ff[15]}}, offset_ff, 31'd0});
      for (int i = 0; i < COMPONENTS; i++) begin
         sum_in = sum_in + $signed({{2{contrib[i][48]}}, contrib[i]});
      end
   end

   assign rnd = sum_ff + 51'sh4000_0000;

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sum_in;
         out_ff <= rnd[49:31];
      end
   end

   assign rsp_valid       = vld_ff[PIPE_LAT-1];
   assign rsp_model_value = out_ff;

`ifndef SYNTH
   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted sample did not enter the pipeline");

   a_stall_freezes : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during a stall");

   a_valid_shifts : assert property (@(posedge clock) disable iff (reset)
      en |=> (vld_ff[PIPE_LAT-1] == $past(vld_ff[PIPE_LAT-2])))
      else $error("valid bit lost or duplicated at the last stage");
`endif

endmodule

`default_nettype wire

/* tb/three_gaussian_sum_eval_tb.sv */
`timescale 1ns / 1ps

module three_gaussian_sum_eval_tb;
   import tgse_pkg::*;

   class model_scoreboard;
      logic [15:0] offset_reg;
      logic [47:0] gauss_reg [3];
      logic [18:0] expected_values [$];
      int          error_count;

      function new();
         offset_reg = '0;
         foreach (gauss_reg[i]) gauss_reg[i] = GAUSS_RESET[i];
         error_count = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [47:0] data);
         case (idx)
            CSR_OFFSET: offset_reg = data[15:0];
            CSR_GAUSS_ONE: gauss_reg[0] = data;
            CSR_GAUSS_TWO: gauss_reg[1] = data;
            CSR_GAUSS_THREE: gauss_reg[2] = data;
            default: ;
         endcase
      endfunction

      function bit [63:0] exp_series(bit [63:0] y);
         bit [63:0] acc;
         bit [63:0] prod;
         acc = 64'd1 << 31;
         for (int k = SERIES_TERMS; k >= 1; k--) begin
            prod = (y * acc + (64'd1 << 30)) >> 31;
            acc = (64'd1 << 31) - (prod + 64'(k / 2)) / 64'(k);
         end
         return acc;
      endfunction

      function longint gaussian_term(logic [47:0] packed_reg, longint t);
         longint    amp;
         longint    pos;
         longint    d;
         bit [63:0] w;
         bit [63:0] ad;
         bit [63:0] d2;
         bit [63:0] w2;
         bit [63:0] e;
         amp = longint'($signed(packed_reg[15:0]));
         pos = longint'($signed(packed_reg[31:16]));
         w = 64'(packed_reg[47:32]);
         if (w == 0) return 0;
         d = t - pos;
         ad = (d < 0) ? 64'(-d) : 64'(d);
         d2 = ad * ad;
         w2 = w * w;
         if (d2 > 32 * w2) return 0;
         e = exp_series((d2 << 25) / w2);
         for (int i = 0; i < SQUARINGS; i++) e = (e * e + (64'd1 << 30)) >> 31;
         return amp * longint'(e);
      endfunction

      function void record_sample(logic [15:0] sample_pos);
         longint t;
         longint total;
         longint rounded;
         t = longint'($signed(sample_pos));
         total = longint'($signed(offset_reg)) * (longint'(1) << 31);
         for (int i = 0; i < COMPONENTS; i++) total += gaussian_term(gauss_reg[i], t);
         rounded = (total + (longint'(1) << 30)) >>> 31;
         expected_values.push_back(rounded[18:0]);
      endfunction

      function void check_value(logic [18:0] model_value);
         logic [18:0] expected;
         if (expected_values.size() == 0) begin
            $error("model_value: no result expected, actual %0d", $signed(model_value));
            error_count++;
            return;
         end
         expected = expected_values.pop_front();
         if (model_value !== expected) begin
            $error("model_value: expected %0d, actual %0d", $signed(expected),
                   $signed(model_value));
            error_count++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_sample_pos;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [18:0] rsp_model_value;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [47:0] csr_wdata;

   model_scoreboard scoreboard;
   bit              quiet_tail;
   int              cycle_count;

   three_gaussian_sum_eval u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_pos  (req_sample_pos),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_model_value (rsp_model_value),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) scoreboard.record_sample(req_sample_pos);
         if (rsp_valid && rsp_ready) scoreboard.check_value(rsp_model_value);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      rsp_ready = 1'b1;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   function automatic logic [47:0] pack_gauss(logic [15:0] amp, logic [15:0] pos,
                                              logic [15:0] width);
      return {width, pos, amp};
   endfunction

   task automatic write_reg(csr_index_type idx, logic [47:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      scoreboard.write_reg(idx, data);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (scoreboard.expected_values.size() != 0) @(posedge clock);
      repeat (COMP_LAT + 20) @(posedge clock);
   endtask

   task automatic send_sample(logic [15:0] t);
      int gap;
      req_valid <= 1'b1;
      req_sample_pos <= t;
      do @(posedge clock); while (!req_ready);
      gap = (!quiet_tail && $urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic random_setup();
      logic [15:0] width;
      write_reg(CSR_OFFSET, 48'($urandom));
      for (int i = 1; i <= 3; i++) begin
         case ($urandom_range(0, 3))
            0: width = 16'($urandom_range(1, 255));
            1: width = 16'($urandom_range(256, 4095));
            2: width = 16'($urandom);
            default: width = '0;
         endcase
         write_reg(csr_index_type'(i), pack_gauss(16'($urandom), 16'($urandom), width));
      end
   endtask

   initial begin
      logic [15:0] t;
      logic [15:0] centre;
      scoreboard = new();
      quiet_tail = 1'b0;
      cycle_count = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_pos = '0;
      csr_we = 1'b0;
      csr_index = CSR_OFFSET;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'h0000);
      send_sample(16'h0280);
      send_sample(16'hFF00);
      drain_results();

      write_reg(CSR_OFFSET, 48'h7FFF);
      write_reg(CSR_GAUSS_ONE, pack_gauss(16'h7FFF, 16'h0000, 16'hFFFF));
      write_reg(CSR_GAUSS_TWO, pack_gauss(16'h7FFF, 16'h0000, 16'hFFFF));
      write_reg(CSR_GAUSS_THREE, pack_gauss(16'h7FFF, 16'h0000, 16'hFFFF));
      send_sample(16'h0000);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      drain_results();

      write_reg(CSR_OFFSET, 48'h8000);
      write_reg(CSR_GAUSS_ONE, pack_gauss(16'h8000, 16'h7FFF, 16'h0100));
      write_reg(CSR_GAUSS_TWO, pack_gauss(16'h8000, 16'h8000, 16'h0001));
      write_reg(CSR_GAUSS_THREE, pack_gauss(16'h1234, 16'h0000, 16'h0000));
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h8001);
      send_sample(16'h7FFA);
      send_sample(16'h7A00);
      send_sample(16'h0000);
      drain_results();

      write_reg(CSR_OFFSET, 48'h0000);
      write_reg(CSR_GAUSS_ONE, pack_gauss(16'h0100, 16'h0000, 16'h0010));
      write_reg(CSR_GAUSS_TWO, '1);
      write_reg(CSR_GAUSS_THREE, '0);
      for (int d = 88; d <= 93; d++) send_sample(16'(d));
      send_sample(16'hFFA5);
      drain_results();

      for (int phase = 0; phase < 7; phase++) begin
         random_setup();
         centre = scoreboard.gauss_reg[$urandom_range(0, 2)][31:16];
         if (phase == 6) quiet_tail = 1'b1;
         for (int n = 0; n < 150; n++) begin
            if ($urandom_range(0, 2) == 0) t = 16'($urandom);
            else t = centre + 16'($signed($urandom_range(0, 2047)) - 1024);
            send_sample(t);
         end
         drain_results();
      end

      if (scoreboard.error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/tgse_pkg.sv
hdl/tgse_div.sv
hdl/tgse_exp.sv
hdl/tgse_comp.sv
hdl/three_gaussian_sum_eval.sv
tb/three_gaussian_sum_eval_tb.sv
